// File: hdl/rnf_pkg.sv
// Shared constants and types for the RNS noise-flooding block.
// Used by every module under hdl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rnf_pkg;

	// Defaults for the top-level parameters
	localparam int NUM_MODULI_DEF   = 4;
	localparam int MODULUS_BITS_DEF = 61;

	// Fixed field widths
	localparam int NOISE_LOW_W  = 64;
	localparam int NOISE_HIGH_W = 63;
	localparam int NOISE_W      = NOISE_LOW_W + NOISE_HIGH_W;
	localparam int NB_W         = 7;
	localparam int IDX_W        = 3;
	localparam int SEL_W        = 2;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_NOISE_BITS   = 3'd0;
	localparam logic [IDX_W-1:0] REG_MODULUS_BASE = 3'd1;

	// Reset values
	localparam logic [NB_W-1:0] NOISE_BITS_RESET = 7'd40;
	localparam logic [63:0]     MODULUS_RESET    = 64'd65537;

	// Output buffer status toward the top level
	typedef struct packed {
		logic advance;
		logic skid_full;
	} out_stat_t;

endpackage

`default_nettype wire

// File: hdl/rns_noise_flood_coefficient_top.sv
// Top level of the RNS noise-flooding block: input stage, reduction cell row,
// final add and output buffer. Depends on rnf_pkg, rnf_front, rnf_cell, rnf_out.
`timescale 1ns / 1ps
`default_nettype none

// Adds flooding noise to one residue coefficient per request. The low
// noise_bits bits of the 127-bit noise word are reduced modulo the selected
// modulus by a row of 127 cells, each shifting in one noise bit and doing one
// compare-and-subtract, then the coefficient is added with one conditional
// subtraction. One request is taken every cycle while in_ready is high; a
// request passes through the input stage, which loads on the accepting edge,
// then the 127 cells and the output register. The output register has one
// skid entry, so in_ready only drops after the sink has held out_ready low
// with a result waiting. Configuration writes take effect at once and are
// meant to happen only while no request is in flight.
module rns_noise_flood_coefficient_top #(
	parameter int NUM_MODULI   = rnf_pkg::NUM_MODULI_DEF,
	parameter int MODULUS_BITS = rnf_pkg::MODULUS_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [rnf_pkg::IDX_W-1:0]               cfg_index,
	input  wire logic [((MODULUS_BITS > rnf_pkg::NB_W) ?
		MODULUS_BITS : rnf_pkg::NB_W)-1:0]                cfg_wdata,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic [rnf_pkg::NOISE_LOW_W-1:0]         noise_low,
	input  wire logic [rnf_pkg::NOISE_HIGH_W-1:0]        noise_high,
	input  wire logic [MODULUS_BITS-1:0]                 coefficient,
	input  wire logic [rnf_pkg::SEL_W-1:0]               modulus_select,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic [MODULUS_BITS-1:0]                      flooded
);

	localparam int CFG_W = (MODULUS_BITS > rnf_pkg::NB_W) ? MODULUS_BITS : rnf_pkg::NB_W;
	localparam int NW    = rnf_pkg::NOISE_W;

	rnf_pkg::out_stat_t      stat;
	logic                    advance;

	logic                    v_c     [NW+1];
	logic [MODULUS_BITS-1:0] q_c     [NW+1];
	logic [MODULUS_BITS-1:0] rem_c   [NW+1];
	logic [MODULUS_BITS-1:0] coef_c  [NW+1];
	logic [NW-1:0]           noise_c [NW+1];

	assign advance  = stat.advance;
	assign in_ready = advance;

	rnf_front #(
		.NUM_MODULI   (NUM_MODULI),
		.MODULUS_BITS (MODULUS_BITS),
		.CFG_W        (CFG_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.en             (advance),
		.in_valid       (in_valid),
		.noise_low      (noise_low),
		.noise_high     (noise_high),
		.coefficient    (coefficient),
		.modulus_select (modulus_select),
		.v_s1           (v_c[0]),
		.noise_s1       (noise_c[0]),
		.q_s1           (q_c[0]),
		.coef_s1        (coef_c[0])
	);

	assign rem_c[0] = '0;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		rnf_cell #(
			.MODULUS_BITS (MODULUS_BITS),
			.NOISE_W      (NW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.v_in      (v_c[i]),
			.q_in      (q_c[i]),
			.rem_in    (rem_c[i]),
			.coef_in   (coef_c[i]),
			.noise_in  (noise_c[i]),
			.v_out     (v_c[i+1]),
			.q_out     (q_c[i+1]),
			.rem_out   (rem_c[i+1]),
			.coef_out  (coef_c[i+1]),
			.noise_out (noise_c[i+1])
		);
	end

	rnf_out #(
		.MODULUS_BITS (MODULUS_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (v_c[NW]),
		.q_in      (q_c[NW]),
		.rem_in    (rem_c[NW]),
		.coef_in   (coef_c[NW]),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.flooded   (flooded),
		.stat      (stat)
	);

	// skid entry only holds a result behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		stat.skid_full |-> out_valid)
		else $error("skid entry full without a waiting result");

	// the row stalls only after the sink refused a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("row stalled without backpressure");

	// skid fills only from a result leaving the last cell
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.skid_full) |-> $past(v_c[NW] && advance))
		else $error("skid entry filled without a result");

endmodule

`default_nettype wire

// File: hdl/rnf_front.sv
// Configuration registers and input stage: noise masking and modulus select.
// Depends on rnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rnf_front #(
	parameter int NUM_MODULI   = rnf_pkg::NUM_MODULI_DEF,
	parameter int MODULUS_BITS = rnf_pkg::MODULUS_BITS_DEF,
	parameter int CFG_W        = rnf_pkg::MODULUS_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rnf_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]                  cfg_wdata,
	input  wire logic                              en,
	input  wire logic                              in_valid,
	input  wire logic [rnf_pkg::NOISE_LOW_W-1:0]   noise_low,
	input  wire logic [rnf_pkg::NOISE_HIGH_W-1:0]  noise_high,
	input  wire logic [MODULUS_BITS-1:0]           coefficient,
	input  wire logic [rnf_pkg::SEL_W-1:0]         modulus_select,
	output logic                                   v_s1,
	output logic [rnf_pkg::NOISE_W-1:0]            noise_s1,
	output logic [MODULUS_BITS-1:0]                q_s1,
	output logic [MODULUS_BITS-1:0]                coef_s1
);

	localparam int IW = rnf_pkg::IDX_W;
	localparam int SW = rnf_pkg::SEL_W;
	localparam int NW = rnf_pkg::NOISE_W;

	logic [rnf_pkg::NB_W-1:0] noise_bits_q;
	logic [MODULUS_BITS-1:0]  mod_q [NUM_MODULI];
	logic [NW-1:0]            noise_mask;
	logic [NW-1:0]            noise_word;
	logic [MODULUS_BITS-1:0]  q_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_bits_q <= rnf_pkg::NOISE_BITS_RESET;
		end else if (cfg_we && cfg_index == rnf_pkg::REG_NOISE_BITS) begin
			noise_bits_q <= cfg_wdata[rnf_pkg::NB_W-1:0];
		end
	end

	for (genvar k = 0; k < NUM_MODULI; k++) begin : g_mod
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mod_q[k] <= MODULUS_BITS'(rnf_pkg::MODULUS_RESET);
			end else if (cfg_we && cfg_index == IW'(int'(rnf_pkg::REG_MODULUS_BASE) + k)) begin
				mod_q[k] <= cfg_wdata[MODULUS_BITS-1:0];
			end
		end
	end

	// keep bits below noise_bits; a count of 127 keeps the whole word
	assign noise_mask = ~({NW{1'b1}} << noise_bits_q);
	assign noise_word = {noise_high, noise_low} & noise_mask;

	// selector past the configured moduli falls back to modulus 0
	always_comb begin
		q_sel = mod_q[0];
		for (int k = 1; k < NUM_MODULI; k++) begin
			if (modulus_select == SW'(k)) begin
				q_sel = mod_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			noise_s1 <= noise_word;
			q_s1     <= q_sel;
			coef_s1  <= coefficient;
		end
	end

endmodule

`default_nettype wire

// File: hdl/rnf_cell.sv
// One step of the restoring reduction: shift in one noise bit, subtract q once.
// Depends on rnf_pkg only for defaults.
`timescale 1ns / 1ps
`default_nettype none

module rnf_cell #(
	parameter int MODULUS_BITS = rnf_pkg::MODULUS_BITS_DEF,
	parameter int NOISE_W      = rnf_pkg::NOISE_W
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    v_in,
	input  wire logic [MODULUS_BITS-1:0] q_in,
	input  wire logic [MODULUS_BITS-1:0] rem_in,
	input  wire logic [MODULUS_BITS-1:0] coef_in,
	input  wire logic [NOISE_W-1:0]      noise_in,
	output logic                         v_out,
	output logic [MODULUS_BITS-1:0]      q_out,
	output logic [MODULUS_BITS-1:0]      rem_out,
	output logic [MODULUS_BITS-1:0]      coef_out,
	output logic [NOISE_W-1:0]           noise_out
);

	logic                    v_q;
	logic [MODULUS_BITS-1:0] q_q;
	logic [MODULUS_BITS-1:0] rem_q;
	logic [MODULUS_BITS-1:0] coef_q;
	logic [NOISE_W-1:0]      noise_q;
	logic [MODULUS_BITS:0]   shifted;
	logic [MODULUS_BITS:0]   reduced;

	// rem < q, so one subtraction brings the shifted value back below q
	assign shifted = {rem_in, noise_in[NOISE_W-1]};
	assign reduced = (shifted >= {1'b0, q_in}) ? shifted - {1'b0, q_in} : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_in) begin
			q_q     <= q_in;
			rem_q   <= reduced[MODULUS_BITS-1:0];
			coef_q  <= coef_in;
			noise_q <= {noise_in[NOISE_W-2:0], 1'b0};
		end
	end

	assign v_out     = v_q;
	assign q_out     = q_q;
	assign rem_out   = rem_q;
	assign coef_out  = coef_q;
	assign noise_out = noise_q;

endmodule

`default_nettype wire

// File: hdl/rnf_out.sv
// Final modular add with one conditional subtraction, then output register
// with a skid entry. Depends on rnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rnf_out #(
	parameter int MODULUS_BITS = rnf_pkg::MODULUS_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    v_in,
	input  wire logic [MODULUS_BITS-1:0] q_in,
	input  wire logic [MODULUS_BITS-1:0] rem_in,
	input  wire logic [MODULUS_BITS-1:0] coef_in,
	input  wire logic                    out_ready,
	output logic                         out_valid,
	output logic [MODULUS_BITS-1:0]      flooded,
	output rnf_pkg::out_stat_t           stat
);

	logic                    out_v_q;
	logic                    skid_v_q;
	logic [MODULUS_BITS-1:0] flooded_q;
	logic [MODULUS_BITS-1:0] skid_q;
	logic [MODULUS_BITS:0]   sum;
	logic [MODULUS_BITS+1:0] diff;
	logic [MODULUS_BITS-1:0] res;
	logic                    advance;
	logic                    push;

	assign sum  = {1'b0, coef_in} + {1'b0, rem_in};
	assign diff = {1'b0, sum} - {2'b00, q_in};

	// zero modulus yields zero; otherwise subtract q if the sum reached it
	always_comb begin
		if (q_in == '0) begin
			res = '0;
		end else if (diff[MODULUS_BITS+1]) begin
			res = sum[MODULUS_BITS-1:0];
		end else begin
			res = diff[MODULUS_BITS-1:0];
		end
	end

	assign advance = !skid_v_q;
	assign push    = v_in && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			flooded_q <= skid_v_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_v_q;
	assign flooded        = flooded_q;
	assign stat.advance   = advance;
	assign stat.skid_full = skid_v_q;

endmodule

`default_nettype wire

// File: tb/flood_residue_checker.sv
// Checker for the RNS noise-flooding block: tracks register writes, predicts the
// flooded residue of each request and compares results in arrival order.
// Depends on rnf_pkg.
`timescale 1ns / 1ps

module flood_residue_checker #(
	parameter int NUM_MODULI   = rnf_pkg::NUM_MODULI_DEF,
	parameter int MODULUS_BITS = rnf_pkg::MODULUS_BITS_DEF,
	parameter int CFG_W        = (MODULUS_BITS > rnf_pkg::NB_W) ? MODULUS_BITS : rnf_pkg::NB_W
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [rnf_pkg::IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_W-1:0]                    cfg_wdata,
	input  wire logic                                in_valid,
	input  wire logic                                in_ready,
	input  wire logic [rnf_pkg::NOISE_LOW_W-1:0]     noise_low,
	input  wire logic [rnf_pkg::NOISE_HIGH_W-1:0]    noise_high,
	input  wire logic [MODULUS_BITS-1:0]             coefficient,
	input  wire logic [rnf_pkg::SEL_W-1:0]           modulus_select,
	input  wire logic                                out_valid,
	input  wire logic                                out_ready,
	input  wire logic [MODULUS_BITS-1:0]             flooded,
	output int                                       mismatch_count,
	output int                                       flooded_pending
);
	import rnf_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic [NB_W-1:0]         noise_width;
	logic [MODULUS_BITS-1:0] modulus [NUM_MODULI];
	logic [MODULUS_BITS-1:0] flooded_due [$];
	logic [MODULUS_BITS-1:0] due_value;
	int                      errors = 0;

	function automatic logic [MODULUS_BITS-1:0] predict_flooded(
		input logic [NOISE_LOW_W-1:0]  lo,
		input logic [NOISE_HIGH_W-1:0] hi,
		input logic [MODULUS_BITS-1:0] coef,
		input logic [SEL_W-1:0]        sel
	);
		logic [NOISE_W:0]        noise;
		logic [NOISE_W:0]        q_wide;
		logic [NOISE_W:0]        rem;
		logic [MODULUS_BITS-1:0] q;
		logic [MODULUS_BITS:0]   sum;
		// out-of-range selectors fall back to the first modulus
		q = (int'(sel) < NUM_MODULI) ? modulus[sel] : modulus[0];
		noise = {1'b0, hi, lo} & (((NOISE_W+1)'(1) << noise_width) - 1'b1);
		if (q == '0)
			return '0;
		q_wide = (NOISE_W+1)'(q);
		rem = noise % q_wide;
		// single conditional subtract, even when coef is not below q
		sum = {1'b0, coef} + {1'b0, rem[MODULUS_BITS-1:0]};
		if (sum >= {1'b0, q})
			sum = sum - {1'b0, q};
		return sum[MODULUS_BITS-1:0];
	endfunction

	task automatic report_failure(input string what);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%0t ns: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_width <= NOISE_BITS_RESET;
			for (int i = 0; i < NUM_MODULI; i++)
				modulus[i] <= MODULUS_BITS'(MODULUS_RESET);
			flooded_due.delete();
			flooded_pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NOISE_BITS)
					noise_width <= cfg_wdata[NB_W-1:0];
				else if (cfg_index >= REG_MODULUS_BASE &&
					int'(cfg_index - REG_MODULUS_BASE) < NUM_MODULI)
					modulus[cfg_index - REG_MODULUS_BASE] <= cfg_wdata[MODULUS_BITS-1:0];
			end
			if (out_valid && out_ready) begin
				if (flooded_due.size() == 0) begin
					report_failure($sformatf("result with no request pending: flooded 0x%h",
						flooded));
				end else begin
					due_value = flooded_due.pop_front();
					if (flooded !== due_value)
						report_failure($sformatf("flooded mismatch: expected 0x%h got 0x%h",
							due_value, flooded));
				end
			end
			if (in_valid && in_ready)
				flooded_due.push_back(predict_flooded(noise_low, noise_high, coefficient,
					modulus_select));
			mismatch_count  <= errors;
			flooded_pending <= flooded_due.size();
		end
	end

endmodule

// File: tb/tb_rns_noise_flood_coefficient_top.sv
// Testbench top for rns_noise_flood_coefficient_top: directed and random requests
// under several register settings and idling patterns. Depends on rnf_pkg,
// the block under hdl/ and flood_residue_checker.
`timescale 1ns / 1ps

module tb_rns_noise_flood_coefficient_top;
	import rnf_pkg::*;

	localparam int MB                 = MODULUS_BITS_DEF;
	localparam int CFG_W              = (MB > NB_W) ? MB : NB_W;
	localparam int CYCLE_LIMIT        = 200000;
	localparam int SETTLE_CYCLES      = 260;
	localparam int RANDOM_PHASES      = 8;
	localparam int REQUESTS_PER_PHASE = 94;
	localparam logic [MB-1:0] MODULUS_MAX = '1;
	localparam logic [MB-1:0] COEF_MAX    = MODULUS_MAX - 1'b1;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [IDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]        cfg_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [NOISE_LOW_W-1:0]  noise_low = '0;
	logic [NOISE_HIGH_W-1:0] noise_high = '0;
	logic [MB-1:0]           coefficient = '0;
	logic [SEL_W-1:0]        modulus_select = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b1;
	logic [MB-1:0]           flooded;
	int                      mismatch_count;
	int                      flooded_pending;

	int                      cycle_count = 0;
	int                      send_idle_pct = 0;
	int                      stall_pct = 0;
	logic [NB_W-1:0]         noise_width_now;
	logic [MB-1:0]           q_now [4];

	rns_noise_flood_coefficient_top #(
		.NUM_MODULI(NUM_MODULI_DEF),
		.MODULUS_BITS(MB)
	) i_dut (.*);

	flood_residue_checker #(
		.NUM_MODULI(NUM_MODULI_DEF),
		.MODULUS_BITS(MB)
	) i_checker (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// sink backpressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [MB-1:0] pick_modulus();
		logic [MB-1:0] m;
		case ($urandom_range(0, 4))
			0: m = MB'(2);
			1: m = MODULUS_MAX;
			2: m = MB'(rand64());
			3: m = MB'($urandom_range(2, 70000));
			default: m = MB'(rand64()) >> $urandom_range(1, MB - 2);
		endcase
		if (m < MB'(2))
			m = MB'(2);
		return m;
	endfunction

	// writes noise width and all moduli from the *_now copies
	task automatic load_settings();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NOISE_BITS;
		cfg_wdata <= CFG_W'(noise_width_now);
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_index <= REG_MODULUS_BASE + IDX_W'(i);
			cfg_wdata <= CFG_W'(q_now[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// leaves valid high after acceptance; the next call or close_burst decides
	task automatic push_request(
		input logic [NOISE_LOW_W-1:0]  lo,
		input logic [NOISE_HIGH_W-1:0] hi,
		input logic [MB-1:0]           coef,
		input logic [SEL_W-1:0]        sel
	);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		noise_low      <= lo;
		noise_high     <= hi;
		coefficient    <= coef;
		modulus_select <= sel;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic push_random_request();
		logic [NOISE_LOW_W-1:0]  lo;
		logic [NOISE_HIGH_W-1:0] hi;
		logic [MB-1:0]           coef;
		logic [MB-1:0]           q;
		logic [SEL_W-1:0]        sel;
		int                      pick;
		sel  = SEL_W'($urandom_range(0, 3));
		q    = q_now[sel];
		lo   = rand64();
		hi   = NOISE_HIGH_W'(rand64());
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			lo = '1;
			hi = '1;
		end else if (pick < 12) begin
			lo = '0;
			hi = '0;
		end
		pick = $urandom_range(0, 99);
		if (q < MB'(2) || pick >= 88) begin
			// coefficient may be at or above q
			coef = MB'(rand64());
			if (coef == MODULUS_MAX)
				coef = COEF_MAX;
		end else if (pick < 70) begin
			coef = MB'(rand64() % 64'(q));
		end else if (pick < 78) begin
			coef = q - 1'b1;
		end else if (pick < 84) begin
			coef = '0;
		end else begin
			coef = COEF_MAX;
		end
		push_request(lo, hi, coef, sel);
	endtask

	task automatic close_burst();
		@(negedge clk);
		in_valid <= 1'b0;
		while (flooded_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		noise_width_now = NOISE_BITS_RESET;
		for (int i = 0; i < 4; i++)
			q_now[i] = MB'(MODULUS_RESET);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: width 40, all moduli 65537
		push_request('0, '0, '0, 2'd0);
		push_request('1, '1, MB'(65536), 2'd1);
		push_request(64'hFFFF_FF00_0000_0000, '1, MB'(1), 2'd2);
		push_request('1, '1, COEF_MAX, 2'd3);
		push_request(64'hAAAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, MB'(12345), 2'd0);
		push_request(64'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, MB'(65535), 2'd3);
		close_burst();

		// full 127-bit noise, widest and narrowest moduli
		noise_width_now = 7'd127;
		q_now[0] = MODULUS_MAX;
		q_now[1] = MB'(2);
		q_now[2] = MB'(65537);
		q_now[3] = pick_modulus();
		load_settings();
		push_request('1, '1, MODULUS_MAX - MB'(2), 2'd0);
		push_request('1, '1, MB'(1), 2'd1);
		push_request('0, 63'h4000_0000_0000_0000, '0, 2'd2);
		push_request(64'h8000_0000_0000_0000, '0, MB'(65536), 2'd2);
		push_request('1, '1, q_now[3] - 1'b1, 2'd3);
		close_burst();

		// zero noise width; zero and one moduli
		noise_width_now = '0;
		q_now[0] = '0;
		q_now[1] = MB'(1);
		q_now[2] = MB'(2);
		q_now[3] = MODULUS_MAX;
		load_settings();
		push_request('1, '1, MB'(123), 2'd0);
		push_request('1, '1, '0, 2'd1);
		push_request('1, '1, MB'(1), 2'd2);
		push_request('1, '1, COEF_MAX, 2'd3);
		close_burst();

		// noise exactly the low word; degenerate moduli with real noise
		noise_width_now = 7'd64;
		q_now[0] = MB'(1);
		q_now[1] = '0;
		q_now[2] = MB'(3);
		q_now[3] = MODULUS_MAX;
		load_settings();
		push_request('1, '1, '0, 2'd0);
		push_request('1, '1, MB'(7), 2'd1);
		push_request('1, '1, MB'(2), 2'd2);
		push_request('1, '1, MB'(5), 2'd2);
		push_request(64'h8000_0000_0000_0000, '1, COEF_MAX, 2'd3);
		close_burst();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: noise_width_now = 7'd1;
				1: noise_width_now = 7'd63;
				2: noise_width_now = 7'd65;
				3: noise_width_now = 7'd64;
				RANDOM_PHASES - 1: noise_width_now = 7'd127;
				default: noise_width_now = NB_W'($urandom_range(1, 127));
			endcase
			for (int i = 0; i < 4; i++)
				q_now[i] = pick_modulus();
			load_settings();
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 46;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 46;
				end
				default: begin
					send_idle_pct = 22;
					stall_pct     = 22;
				end
			endcase
			repeat (REQUESTS_PER_PHASE)
				push_random_request();
			close_burst();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && flooded_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: rns_noise_flood_coefficient_top.f
hdl/rnf_pkg.sv
hdl/rnf_front.sv
hdl/rnf_cell.sv
hdl/rnf_out.sv
hdl/rns_noise_flood_coefficient_top.sv
tb/flood_residue_checker.sv
tb/tb_rns_noise_flood_coefficient_top.sv
